// ===== rtl/hlbc_pkg.sv =====
// ---------------------------------------------------------------------------
// hlbc_pkg
// Shared types and constants for the hashed LRU buffer cache.
// ---------------------------------------------------------------------------
package hlbc_pkg;
  localparam int NUM_BUFFERS_DEF = 32;
  localparam int NUM_BUCKETS_DEF = 13;
  localparam int REF_MAX = 255;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_t;
endpackage

// ===== rtl/hlbc_mod.sv =====
// ---------------------------------------------------------------------------
// hlbc_mod
// Remainder of a 32-bit block number by the bucket count, one byte a cycle
// through two constant tables and a single compare and subtract.
// ---------------------------------------------------------------------------
module hlbc_mod import hlbc_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   value,
  output logic          done,
  output logic [BW-1:0] rem
);
  localparam logic [BW:0] NB = (BW+1)'(NUM_BUCKETS);
  logic [31:0]   sh;
  logic [1:0]    cnt;
  logic          busy;
  logic [BW:0]   sum;
  logic [BW-1:0] atab [2**BW];
  logic [BW-1:0] btab [256];

  for (genvar g = 0; g < 2**BW; g++) begin : g_atab
    assign atab[g] = BW'((g * 256) % NUM_BUCKETS);
  end

  for (genvar g = 0; g < 256; g++) begin : g_btab
    assign btab[g] = BW'(g % NUM_BUCKETS);
  end

  assign sum = {1'b0, atab[rem]} + {1'b0, btab[sh[31:24]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      sh   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sh   <= value;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        rem <= (sum >= NB) ? BW'(sum - NB) : BW'(sum);
        sh  <= {sh[23:0], 8'd0};
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/hashed_lru_buffer_cache_top.sv =====
// Pin, unpin and a release that keeps a reference go from idle straight to the
// output state; a release to zero first passes S_REL, S_MOD, S_URD, S_UNL, S_PRD,
// S_PUSH1 and S_PUSH2. Acquire: hlbc_mod gives the bucket, then the bucket list is
// walked for a hit and the lists for a free buffer. One item at a time, ready low
// meanwhile. Reset clears tags, counts and valid bits; links are rebuilt by a sweep
// through S_INIT, S_PUSH1 and S_PUSH2 during which no item is taken.
// ---------------------------------------------------------------------------
// hashed_lru_buffer_cache_top
// Tag store and per-bucket recency lists walked by a small sequencer.
// ---------------------------------------------------------------------------
module hashed_lru_buffer_cache_top import hlbc_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  dev,
  input  logic [31:0] block_num,
  input  logic [4:0]  buf_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  slot,
  output logic        hit,
  output logic        need_read,
  output logic        status
);
  localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
  localparam int NW = $clog2(NODES + 1);
  localparam int BIW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [NW-1:0] NBUF = NW'(NUM_BUFFERS);

  typedef enum logic [13:0] {
    S_INIT   = 14'h0001,
    S_IDLE   = 14'h0002,
    S_MOD    = 14'h0004,
    S_SRCH   = 14'h0008,
    S_FREE   = 14'h0010,
    S_ONEXT  = 14'h0020,
    S_URD    = 14'h0040,
    S_UNL    = 14'h0080,
    S_PRD    = 14'h0100,
    S_PUSH1  = 14'h0200,
    S_PUSH2  = 14'h0400,
    S_GRANT  = 14'h0800,
    S_OUT    = 14'h1000,
    S_REL    = 14'h2000
  } state_t;

  state_t state;
  logic [7:0]    tdev  [NUM_BUFFERS];
  logic [31:0]   tblk  [NUM_BUFFERS];
  logic          vld   [NUM_BUFFERS];
  logic [7:0]    rc    [NUM_BUFFERS];
  logic [NW-1:0] nxt   [NODES];
  logic [NW-1:0] prv   [NODES];

  logic [1:0]    rq;
  logic [7:0]    rdev;
  logic [31:0]   rblk;
  logic [4:0]    ridx;
  logic [BW-1:0] bkt, ibkt;
  logic [BW:0]   kscan;
  logic [NW-1:0] head, cur, node, hd2;
  logic [NW-1:0] guard;
  logic [NW:0]   icnt;
  logic          stolen;

  logic [NW-1:0] n_ra, p_ra, n_wa, p_wa, n_wd, p_wd, nxt_q, prv_q;
  logic          n_we, p_we;

  logic          mstart, mdone;
  logic [31:0]   mval;
  logic [BW-1:0] mrem;

  hlbc_mod #(.NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_mod (
    .clk(clk), .rst(rst), .start(mstart), .value(mval), .done(mdone), .rem(mrem)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  logic [BIW-1:0] ci, fi, ni;
  assign ci = nxt_q[BIW-1:0];
  assign fi = prv_q[BIW-1:0];
  assign ni = node[BIW-1:0];

  always_comb begin
    mstart = 1'b0;
    mval   = block_num;
    if (state == S_IDLE && in_valid && req_t'(req_type) == REQ_ACQUIRE) mstart = 1'b1;
    if (state == S_REL) begin
      mstart = 1'b1;
      mval   = tblk[ridx[BIW-1:0]];
    end
  end

  always_comb begin
    n_ra = head;
    p_ra = head;
    n_we = 1'b0;
    n_wa = node;
    n_wd = nxt_q;
    p_we = 1'b0;
    p_wa = node;
    p_wd = head;
    case (state)
      S_INIT: begin
        n_ra = NBUF + NW'(ibkt);
        if (icnt < (NW+1)'(NUM_BUCKETS)) begin
          n_we = 1'b1;
          n_wa = NBUF + NW'(icnt);
          n_wd = NBUF + NW'(icnt);
          p_we = 1'b1;
          p_wa = NBUF + NW'(icnt);
          p_wd = NBUF + NW'(icnt);
        end
      end
      S_MOD: n_ra = NBUF + NW'(mrem);
      S_SRCH: n_ra = nxt_q;
      S_FREE: p_ra = prv_q;
      S_ONEXT: begin
        if (kscan < (BW+1)'(NUM_BUCKETS)) p_ra = NBUF + NW'(kscan);
      end
      S_URD: begin
        n_ra = node;
        p_ra = node;
      end
      S_UNL: begin
        n_we = 1'b1;
        n_wa = prv_q;
        n_wd = nxt_q;
        p_we = 1'b1;
        p_wa = nxt_q;
        p_wd = prv_q;
      end
      S_PUSH1: begin
        n_we = 1'b1;
        n_wa = node;
        n_wd = nxt_q;
        p_we = 1'b1;
        p_wa = node;
        p_wd = head;
      end
      S_PUSH2: begin
        n_we = 1'b1;
        n_wa = head;
        n_wd = node;
        p_we = 1'b1;
        p_wa = cur;
        p_wd = node;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    nxt_q <= nxt[n_ra];
    prv_q <= prv[p_ra];
    if (n_we) nxt[n_wa] <= n_wd;
    if (p_we) prv[p_wa] <= p_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      icnt  <= '0;
      ibkt  <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tdev[i] <= '0;
        tblk[i] <= '0;
        vld[i]  <= 1'b0;
        rc[i]   <= '0;
      end
    end else begin
      case (state)
        S_INIT: begin
          icnt <= icnt + 1'b1;
          if (icnt >= (NW+1)'(NUM_BUCKETS)) begin
            node <= NW'(icnt - (NW+1)'(NUM_BUCKETS));
            head <= NBUF + NW'(ibkt);
            ibkt <= (ibkt == BW'(NUM_BUCKETS - 1)) ? '0 : ibkt + 1'b1;
            if (icnt == (NW+1)'(NODES)) state <= S_IDLE;
            else state <= S_PUSH1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rq <= req_type; rdev <= dev; rblk <= block_num; ridx <= buf_index;
            slot <= buf_index; hit <= 1'b0; need_read <= 1'b0; status <= 1'b0;
            stolen <= 1'b0;
            if (req_t'(req_type) == REQ_ACQUIRE) state <= S_MOD;
            else if ({1'b0, buf_index} >= 6'(NUM_BUFFERS)) state <= S_OUT;
            else begin
              case (req_t'(req_type))
                REQ_PIN: begin
                  if (rc[buf_index[BIW-1:0]] != 8'(REF_MAX))
                    rc[buf_index[BIW-1:0]] <= rc[buf_index[BIW-1:0]] + 8'd1;
                  state <= S_OUT;
                end
                REQ_UNPIN: begin
                  if (rc[buf_index[BIW-1:0]] != 8'd0)
                    rc[buf_index[BIW-1:0]] <= rc[buf_index[BIW-1:0]] - 8'd1;
                  state <= S_OUT;
                end
                default: begin
                  if (rc[buf_index[BIW-1:0]] == 8'd1) state <= S_REL;
                  else begin
                    if (rc[buf_index[BIW-1:0]] != 8'd0)
                      rc[buf_index[BIW-1:0]] <= rc[buf_index[BIW-1:0]] - 8'd1;
                    state <= S_OUT;
                  end
                end
              endcase
            end
          end
        end
        S_REL: begin
          rc[ridx[BIW-1:0]] <= 8'd0;
          node <= NW'(ridx);
          state <= S_MOD;
        end
        S_MOD: begin
          if (mdone) begin
            bkt  <= mrem;
            head <= NBUF + NW'(mrem);
            if (rq == 2'(REQ_ACQUIRE)) begin
              guard <= '0;
              state <= S_SRCH;
            end else state <= S_URD;
          end
        end
        S_SRCH: begin
          if (nxt_q == head || nxt_q >= NBUF || guard == NW'(NODES)) begin
            hd2 <= head;
            guard <= '0;
            state <= S_FREE;
          end else if (tdev[ci] == rdev && tblk[ci] == rblk) begin
            hit <= 1'b1;
            if (rc[ci] != 8'(REF_MAX)) rc[ci] <= rc[ci] + 8'd1;
            node <= nxt_q;
            state <= S_GRANT;
          end else begin
            guard <= guard + 1'b1;
          end
        end
        S_FREE: begin
          if (prv_q == hd2 || prv_q >= NBUF || guard == NW'(NODES)) begin
            if (!stolen) begin
              stolen <= 1'b1;
              kscan <= '0;
            end else kscan <= kscan + 1'b1;
            state <= S_ONEXT;
          end else if (rc[fi] == 8'd0) begin
            node <= prv_q;
            tdev[fi] <= rdev; tblk[fi] <= rblk; vld[fi] <= 1'b0; rc[fi] <= 8'd1;
            if (stolen) state <= S_URD;
            else state <= S_GRANT;
          end else begin
            guard <= guard + 1'b1;
          end
        end
        S_ONEXT: begin
          if (kscan >= (BW+1)'(NUM_BUCKETS)) begin
            slot <= '0; status <= 1'b1; state <= S_OUT;
          end else if (kscan == {1'b0, bkt}) kscan <= kscan + 1'b1;
          else begin
            hd2 <= NBUF + NW'(kscan);
            guard <= '0;
            state <= S_FREE;
          end
        end
        S_URD: state <= S_UNL;
        S_UNL: state <= S_PRD;
        S_PRD: state <= S_PUSH1;
        S_PUSH1: begin
          cur <= nxt_q;
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (icnt <= (NW+1)'(NODES)) state <= S_INIT;
          else if (rq == 2'(REQ_ACQUIRE)) state <= S_GRANT;
          else state <= S_OUT;
        end
        S_GRANT: begin
          slot <= 5'(node);
          need_read <= ~vld[ni];
          vld[ni] <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
